FILE: design/vpt_pkg.sv
package vpt_pkg;

  localparam int unsigned NUM_ROWS = 4;
  localparam int unsigned ROW_W    = 64;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned COMP_W   = 32;
  localparam int unsigned PROD_W   = COEF_W + COMP_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_ROW_0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROW_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_ROW_3 = 2'd3;

  // identity in Q4.12
  localparam logic [ROW_W-1:0] ROW_0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_3_RST = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic              ovf;
    logic [COMP_W-1:0] val;
  } div_res_t;

endpackage

FILE: design/vpt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Computes (num << FRAC) / den, truncated toward zero, saturated to 32 bits.
// den == 0 passes num through with no overflow.
module vpt_div
  import vpt_pkg::*;
#(
  parameter int unsigned FRAC = 16
) (
  input  logic              clk_i,
  input  logic              ce_i,
  input  logic [COMP_W-1:0] num_i,
  input  logic [COMP_W-1:0] den_i,
  output div_res_t          res_o
);

  localparam int unsigned NW = COMP_W + FRAC;

  logic [COMP_W-1:0] rem_q  [0:NW];
  logic [NW-1:0]     dvd_q  [0:NW];
  logic [NW-1:0]     quo_q  [0:NW];
  logic [COMP_W-1:0] dvs_q  [0:NW];
  logic              neg_q  [0:NW];
  logic              zero_q [0:NW];
  logic [COMP_W-1:0] num_q  [0:NW];
  div_res_t          res_q;

  logic [COMP_W-1:0] num_abs, den_abs;

  assign num_abs = num_i[COMP_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_abs = den_i[COMP_W-1] ? (~den_i + 1'b1) : den_i;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0]  <= '0;
      dvd_q[0]  <= {num_abs, {FRAC{1'b0}}};
      quo_q[0]  <= '0;
      dvs_q[0]  <= den_abs;
      neg_q[0]  <= num_i[COMP_W-1] ^ den_i[COMP_W-1];
      zero_q[0] <= (den_i == '0);
      num_q[0]  <= num_i;
    end
  end

  for (genvar s = 1; s <= NW; s++) begin : g_stage
    logic [COMP_W:0]   trial;
    logic              ge;
    logic [COMP_W:0]   diff;

    assign trial = {rem_q[s-1], dvd_q[s-1][NW-1]};
    assign ge    = (trial >= {1'b0, dvs_q[s-1]});
    assign diff  = trial - {1'b0, dvs_q[s-1]};

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[s]  <= ge ? diff[COMP_W-1:0] : trial[COMP_W-1:0];
        dvd_q[s]  <= {dvd_q[s-1][NW-2:0], 1'b0};
        quo_q[s]  <= {quo_q[s-1][NW-2:0], ge};
        dvs_q[s]  <= dvs_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        num_q[s]  <= num_q[s-1];
      end
    end
  end

  logic [NW-1:0]     qmag;
  logic              ovf_pos, ovf_neg;
  div_res_t          res_d;

  assign qmag    = quo_q[NW];
  assign ovf_pos = |qmag[NW-1:COMP_W-1];
  assign ovf_neg = (|qmag[NW-1:COMP_W]) || (qmag[COMP_W-1] && (|qmag[COMP_W-2:0]));

  always_comb begin
    res_d = '0;
    if (zero_q[NW]) begin
      res_d.val = num_q[NW];
      res_d.ovf = 1'b0;
    end else if (neg_q[NW]) begin
      res_d.ovf = ovf_neg;
      res_d.val = ovf_neg ? {1'b1, {(COMP_W-1){1'b0}}} : (~qmag[COMP_W-1:0] + 1'b1);
    end else begin
      res_d.ovf = ovf_pos;
      res_d.val = ovf_pos ? {1'b0, {(COMP_W-1){1'b1}}} : qmag[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: design/vertex_projection_transform.sv
// Pipeline from accepted word to output word: four matrix stages, then one divider
// stage per quotient bit plus entry and saturation registers.
// Throughput: one vertex per cycle; the whole pipe stalls only while the output word waits.
// Reset: valid bits clear, matrix returns to identity; datapath registers are not reset.
module vertex_projection_transform
  import vpt_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 12,
  parameter int unsigned VEC_FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [ROW_W-1:0]      cfg_data_i,
  // input vertex stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [4*COMP_W-1:0]   s_axis_tdata,   // vec_x, vec_y, vec_z, vec_w
  // output vertex stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [4*COMP_W-1:0]   m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic [1:0]            m_axis_tuser    // w_was_zero, saturated
);

  localparam int unsigned DIV_LAT = COMP_W + VEC_FRAC_BITS + 2;

  // ---------------------------------------------------------------- matrix
  logic [ROW_W-1:0] row_q [NUM_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_0_RST;
      row_q[1] <= ROW_1_RST;
      row_q[2] <= ROW_2_RST;
      row_q[3] <= ROW_3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_0: row_q[0] <= cfg_data_i;
        REG_ROW_1: row_q[1] <= cfg_data_i;
        REG_ROW_2: row_q[2] <= cfg_data_i;
        REG_ROW_3: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Global advance: the pipe moves whenever the output slot is free or drains.
  logic ce;
  logic out_vld;

  assign ce            = !out_vld || m_axis_tready;
  assign s_axis_tready = ce;

  // ---------------------------------------------------------------- stage 1: input register
  logic              v1_q;
  logic [COMP_W-1:0] vec_q [NUM_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ce) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int j = 0; j < NUM_ROWS; j++) begin
        vec_q[j] <= s_axis_tdata[j*COMP_W +: COMP_W];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: 16 products
  logic                     v2_q;
  logic signed [PROD_W-1:0] prod_q [NUM_ROWS][NUM_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ce) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        for (int j = 0; j < NUM_ROWS; j++) begin
          prod_q[i][j] <= $signed(row_q[i][j*COEF_W +: COEF_W]) * $signed(vec_q[j]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: row sums
  logic                    v3_q;
  logic signed [SUM_W-1:0] sum_q [NUM_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ce) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        sum_q[i] <= SUM_W'(prod_q[i][0]) + SUM_W'(prod_q[i][1])
                  + SUM_W'(prod_q[i][2]) + SUM_W'(prod_q[i][3]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: shift + clamp
  // >>> floors toward minus infinity, then clamp to int32.
  logic              v4_q;
  logic [COMP_W-1:0] r_q [NUM_ROWS];
  logic              sat4_q;
  logic              wz4_q;

  logic signed [SUM_W-1:0] shr    [NUM_ROWS];
  logic [COMP_W-1:0]       r_d    [NUM_ROWS];
  logic [NUM_ROWS-1:0]     clamp;

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      shr[i]   = sum_q[i] >>> COEF_FRAC_BITS;
      clamp[i] = !((&shr[i][SUM_W-1:COMP_W-1]) || !(|shr[i][SUM_W-1:COMP_W-1]));
      if (!clamp[i]) begin
        r_d[i] = shr[i][COMP_W-1:0];
      end else if (shr[i][SUM_W-1]) begin
        r_d[i] = {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
        r_d[i] = {1'b0, {(COMP_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ce) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        r_q[i] <= r_d[i];
      end
      sat4_q <= |clamp;
      wz4_q  <= (r_d[3] == '0);
    end
  end

  // ---------------------------------------------------------------- divide x, y, z by w
  div_res_t div_res [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    vpt_div #(
      .FRAC (VEC_FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .ce_i   (ce),
      .num_i  (r_q[c]),
      .den_i  (r_q[3]),
      .res_o  (div_res[c])
    );
  end

  // side band rides alongside the divider
  logic              vd_q   [DIV_LAT];
  logic [COMP_W-1:0] wd_q   [DIV_LAT];
  logic              satd_q [DIV_LAT];
  logic              wzd_q  [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (ce) begin
      vd_q[0] <= v4_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      wd_q[0]   <= r_q[3];
      satd_q[0] <= sat4_q;
      wzd_q[0]  <= wz4_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        wd_q[k]   <= wd_q[k-1];
        satd_q[k] <= satd_q[k-1];
        wzd_q[k]  <= wzd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_vld       = vd_q[DIV_LAT-1];
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {wd_q[DIV_LAT-1], div_res[2].val, div_res[1].val, div_res[0].val};
  assign m_axis_tuser  = {satd_q[DIV_LAT-1] | div_res[0].ovf | div_res[1].ovf | div_res[2].ovf,
                          wzd_q[DIV_LAT-1]};

endmodule

FILE: tb/vertex_projection_transform_tb.sv
module vertex_projection_transform_tb;
  import vpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COEF_FRAC = 12;
  localparam int unsigned VEC_FRAC  = 16;
  // pipe depth from the RTL header, plus margin for the drain wait
  localparam int unsigned PIPE_LAT  = 4 + 32 + VEC_FRAC + 2;
  localparam int unsigned DRAIN_CYC = PIPE_LAT + 20;
  // idle-cycle watchdog: longest receiver stall run and pipe fill, times margin
  localparam int unsigned WDOG_LIM  = 20000;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // idle phases
  typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_ph_e;

  typedef struct packed {
    logic [31:0] x, y, z, w;
    logic        wzero, sat;
  } vtx_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IDX_W-1:0]     cfg_idx_i = '0;
  logic [ROW_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [4*COMP_W-1:0]  s_axis_tdata = '0;   // vec_x, vec_y, vec_z, vec_w
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [4*COMP_W-1:0]  m_axis_tdata;        // out_x, out_y, out_z, out_w
  logic [1:0]           m_axis_tuser;        // w_was_zero, saturated

  vertex_projection_transform #(
    .COEF_FRAC_BITS(COEF_FRAC),
    .VEC_FRAC_BITS (VEC_FRAC)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the matrix rows
  logic [ROW_W-1:0] mat_row [NUM_ROWS];
  vtx_res_t         exp_vtx_q [$];
  idle_ph_e         idle_ph = PH_NONE;
  int unsigned      n_err = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_got = 0;
  int unsigned      n_wzero = 0;
  int unsigned      n_sat = 0;
  int unsigned      idle_cyc = 0;
  bit               timed_out = 1'b0;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                 inout logic sat);
    if (v > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // matrix times vertex, >>> COEF_FRAC, clamp, then divide by w unless zero
  function automatic vtx_res_t project_vertex(input logic [127:0] vin);
    logic signed [63:0] comp [4];
    logic signed [63:0] res  [4];
    logic signed [63:0] acc;
    logic signed [15:0] coef;
    logic               sat;
    vtx_res_t           r;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) comp[i] = $signed(vin[32*i +: 32]);
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        coef = mat_row[i][16*j +: 16];
        acc += 64'(coef) * comp[j];
      end
      res[i] = clamp32(acc >>> COEF_FRAC, sat);
    end
    r.wzero = (res[3] == 0);
    if (!r.wzero)
      for (int i = 0; i < 3; i++)
        res[i] = clamp32((res[i] <<< VEC_FRAC) / res[3], sat);   // truncates toward zero
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
    r.w = res[3][31:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic write_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mat_row[idx] = val;
  endtask

  // wait for all words out, then let the pipe settle before a config write
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (exp_vtx_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // valid stays high between back-to-back words; it drops only for idle cycles
  task automatic send_vertex(input logic [31:0] x, y, z, w);
    if (idle_ph == PH_SRC || idle_ph == PH_BOTH) begin
      while ($urandom_range(99) < (idle_ph == PH_SRC ? 79 : 6)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_vtx_q.push_back(project_vertex({w, z, y, x}));
    n_sent++;
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    case (idle_ph)
      PH_SNK:  m_axis_tready <= ($urandom_range(99) >= 79);
      PH_BOTH: m_axis_tready <= ($urandom_range(99) >= 6);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  // output word check
  always @(posedge clk_i) begin
    vtx_res_t exp_v, got_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_v = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1]};
      n_got++;
      if (exp_vtx_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected output word %h", m_axis_tdata);
      end else begin
        exp_v = exp_vtx_q.pop_front();
        if (got_v.wzero) n_wzero++;
        if (got_v.sat) n_sat++;
        if (got_v !== exp_v) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch word %0d: exp x=%h y=%h z=%h w=%h wz=%b sat=%b",
                     n_got, exp_v.x, exp_v.y, exp_v.z, exp_v.w, exp_v.wzero, exp_v.sat,
                     "  got x=%h y=%h z=%h w=%h wz=%b sat=%b",
                     got_v.x, got_v.y, got_v.z, got_v.w, got_v.wzero, got_v.sat);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIM) begin
      timed_out = 1'b1;
      $display("watchdog: no progress, %0d words outstanding", exp_vtx_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_comp;
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(32'h0004_0000) - 32'h0002_0000;   // near unit range
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd_coef;
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return 16'($urandom_range(16'h2000)) - 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rnd_row;
    return {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()};
  endfunction

  // identity matrix: extremes of every component, zero w, overflow
  task automatic test_identity_edges;
    mat_row[0] = ROW_0_RST;
    mat_row[1] = ROW_1_RST;
    mat_row[2] = ROW_2_RST;
    mat_row[3] = ROW_3_RST;
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000); // w zero
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001); // quotient clamps
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff);
    send_vertex(32'hfff0_0000, 32'h0010_0000, 32'h1234_5678, 32'hffff_0000);
    send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    send_vertex(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
  endtask

  // extreme coefficients: dot products overflow, negative w floors to -1
  task automatic test_extreme_matrix;
    drain();
    write_row(REG_ROW_0, 64'h7fff_7fff_7fff_7fff);
    write_row(REG_ROW_1, 64'h8000_8000_8000_8000);
    write_row(REG_ROW_2, 64'h0000_0000_0000_0000);
    write_row(REG_ROW_3, 64'h0000_0000_0000_0001);   // tiny w coefficient
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000); // w = -1 after shift
    send_vertex(32'h0000_0fff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000); // w shifts to zero
    send_vertex(32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 32'h0000_1000);
    drain();
    write_row(REG_ROW_0, 64'h8000_0000_0000_7fff);
    write_row(REG_ROW_1, 64'hffff_ffff_ffff_ffff);
    write_row(REG_ROW_2, 64'h7fff_8000_7fff_8000);
    write_row(REG_ROW_3, 64'h8000_8000_8000_8000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff);
    send_vertex($urandom, $urandom, $urandom, $urandom);
  endtask

  // random vertices, matrix changed between phases, all idle phases
  task automatic test_random_stream;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      for (int r = 0; r < NUM_ROWS; r++)
        if ($urandom_range(3) != 0) write_row(IDX_W'(r), rnd_row());
      idle_ph = idle_ph_e'(ph % 4);
      for (int n = 0; n < 104; n++)
        send_vertex(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
    end
    idle_ph = PH_NONE;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_edges();
    test_extreme_matrix();
    test_random_stream();
    drain();
    $display("sent %0d vertices, checked %0d words (%0d with zero w, %0d clamped)",
             n_sent, n_got, n_wzero, n_sat);
    $display("over identity, extreme and random matrices under four idle patterns");
    if (n_err == 0 && exp_vtx_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d words missing", n_err, exp_vtx_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
